// ===== rtl/ali_pkg.sv =====
// ----------------------------------------------------------------------------
// ali_pkg
// Shared types, constants and the control store for the activity level
// integrator: field widths, signal classes, register indexes, microcode.
// ----------------------------------------------------------------------------
package ali_pkg;

  // Field widths
  localparam int CLS_W   = 2;
  localparam int CONTR_W = 16;
  localparam int ELAP_W  = 32;
  localparam int LEVEL_W = 16;
  localparam int RATE_W  = 8;
  localparam int PER_W   = 16;
  localparam int MAX_W   = 8;
  localparam int CIDX_W  = 4;
  localparam int CDAT_W  = 16;
  localparam int FRAC_W  = 8;

  // Signal classes
  localparam logic [CLS_W-1:0] CLS_LOW   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_HIGH  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_BLINK = 2'd2;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_RISE_RATE    = 4'd0,
    CFG_DECAY_RATE   = 4'd1,
    CFG_UPDATE_PER   = 4'd2,
    CFG_LEVEL_MAX    = 4'd3
  } cfg_idx_t;

  // Sequencer step addresses
  typedef logic [2:0] step_t;
  localparam step_t STEP_FETCH  = 3'd0;
  localparam step_t STEP_PREP   = 3'd1;
  localparam step_t STEP_SUM    = 3'd2;
  localparam step_t STEP_CHECK  = 3'd3;
  localparam step_t STEP_DIV    = 3'd4;
  localparam step_t STEP_COMMIT = 3'd5;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_FETCH,
    OP_PREP,
    OP_SUM,
    OP_CHECK,
    OP_DIV_WAIT,
    OP_COMMIT
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    CND_NEVER,
    CND_NO_ITEM,
    CND_NO_TERM,
    CND_SAT,
    CND_DIV_BUSY,
    CND_OUT_FULL
  } cond_t;

  // One control word
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jmp;
    step_t nxt;
  } ucode_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic no_item;
    logic no_term;
    logic sat;
    logic div_busy;
    logic out_full;
  } status_t;

  // Control store
  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    case (pc)
      STEP_FETCH:  w = '{op: OP_FETCH,    cond: CND_NO_ITEM,  jmp: STEP_FETCH,
                         nxt: STEP_PREP};
      STEP_PREP:   w = '{op: OP_PREP,     cond: CND_NO_TERM,  jmp: STEP_COMMIT,
                         nxt: STEP_SUM};
      STEP_SUM:    w = '{op: OP_SUM,      cond: CND_NEVER,    jmp: STEP_SUM,
                         nxt: STEP_CHECK};
      STEP_CHECK:  w = '{op: OP_CHECK,    cond: CND_SAT,      jmp: STEP_COMMIT,
                         nxt: STEP_DIV};
      STEP_DIV:    w = '{op: OP_DIV_WAIT, cond: CND_DIV_BUSY, jmp: STEP_DIV,
                         nxt: STEP_COMMIT};
      STEP_COMMIT: w = '{op: OP_COMMIT,   cond: CND_OUT_FULL, jmp: STEP_COMMIT,
                         nxt: STEP_FETCH};
      default:     w = '{op: OP_FETCH,    cond: CND_NO_ITEM,  jmp: STEP_FETCH,
                         nxt: STEP_PREP};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/ali_ifs.sv =====
// ----------------------------------------------------------------------------
// ali_ifs
// Valid/ready channels of the activity level integrator: input items,
// result items and configuration writes.
// ----------------------------------------------------------------------------
interface ali_in_if import ali_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CLS_W-1:0]          signal_class;
  logic signed [CONTR_W-1:0] contribution;
  logic [ELAP_W-1:0]         elapsed_ms;

  modport source (output valid, signal_class, contribution, elapsed_ms, input ready);
  modport sink   (input valid, signal_class, contribution, elapsed_ms, output ready);
endinterface

interface ali_out_if import ali_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, level, input ready);
  modport sink   (input valid, level, output ready);
endinterface

interface ali_cfg_if import ali_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] wr_index;
  logic [CDAT_W-1:0] wr_data;

  modport source (output valid, wr_index, wr_data, input ready);
  modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

// ===== rtl/ali_seq.sv =====
// ----------------------------------------------------------------------------
// ali_seq
// Microcode sequencer: step counter, control store lookup and conditional
// jump on one datapath status flag per step.
// ----------------------------------------------------------------------------
module ali_seq import ali_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  status_t sts,
  output ucode_t  uc
);

  step_t pc_r;
  step_t pc_nxt;
  logic  take_jmp;

  // Fetch the control word of the current step
  assign uc = ucode_rom(pc_r);

  // Evaluate the jump condition
  always_comb begin
    case (uc.cond)
      CND_NEVER:    take_jmp = 1'b0;
      CND_NO_ITEM:  take_jmp = sts.no_item;
      CND_NO_TERM:  take_jmp = sts.no_term;
      CND_SAT:      take_jmp = sts.sat;
      CND_DIV_BUSY: take_jmp = sts.div_busy;
      CND_OUT_FULL: take_jmp = sts.out_full;
      default:      take_jmp = 1'b0;
    endcase
  end

  assign pc_nxt = take_jmp ? uc.jmp : uc.nxt;

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/ali_div.sv =====
// ----------------------------------------------------------------------------
// ali_div
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one quotient
// bit per cycle. Quotient is taken as 16 bits; callers keep it in range.
// ----------------------------------------------------------------------------
module ali_div import ali_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [31:0]       dividend,
  input  logic [PER_W-1:0]  divisor,
  output logic              busy,
  output logic [LEVEL_W-1:0] quotient,
  output logic [PER_W-1:0]  remainder
);

  logic              busy_r;
  logic [4:0]        cnt_r;
  logic [31:0]       quo_r;
  logic [PER_W-1:0]  rem_r;
  logic [PER_W-1:0]  dsr_r;
  logic [PER_W:0]    rem_sh;
  logic [PER_W+1:0]  diff;

  // Shift in the next dividend bit and trial-subtract
  assign rem_sh = {rem_r, quo_r[31]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_r};

  // Control: count 32 iterations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'd31;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath: quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[30:0], ~diff[PER_W+1]};
      rem_r <= diff[PER_W+1] ? rem_sh[PER_W-1:0] : diff[PER_W-1:0];
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r[LEVEL_W-1:0];
  assign remainder = rem_r;

endmodule

// ===== rtl/activity_level_integrator.sv =====
// ----------------------------------------------------------------------------
// activity_level_integrator
// Q8.8 activity level that rises or decays at a configured rate scaled by
// elapsed time, with carried division remainders and saturation.
// ----------------------------------------------------------------------------
// An item is taken only once the previous one has been through every step:
// take the item, form the products, sum and check for saturation, wait on
// the bit-serial divider for its 32 quotient bits and capture the result,
// then update the level. Items with no rate term (blinking class, zero rate,
// zero period or zero elapsed time) go from the products straight to the
// level update, and saturated terms skip the divider. The result sits in an
// output register, so the next item is taken while it waits; a new level is
// written only once the previous one has been taken. Configuration writes
// are always accepted and must be made while idle.
// ----------------------------------------------------------------------------
module activity_level_integrator import ali_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ali_in_if.sink    in_chan,
  ali_out_if.source out_chan,
  ali_cfg_if.sink   cfg_chan
);

  // Configuration registers
  logic [RATE_W-1:0] rise_rate_r;
  logic [RATE_W-1:0] decay_rate_r;
  logic [PER_W-1:0]  period_r;
  logic [MAX_W-1:0]  max_r;

  // Persistent state
  logic [LEVEL_W-1:0] level_r;
  logic [PER_W-1:0]   rise_rem_r;
  logic [PER_W-1:0]   decay_rem_r;

  // Item and working registers
  logic [CLS_W-1:0]          cls_r;
  logic signed [CONTR_W-1:0] contrib_r;
  logic [ELAP_W-1:0]         elapsed_r;
  logic [ELAP_W+RATE_W-1:0]  prod_r;
  logic [31:0]               mp_r;
  logic [31:0]               dvd_r;
  logic                      sat_r;
  logic [LEVEL_W-1:0]        term_r;
  logic [PER_W-1:0]          rem_new_r;

  // Output register
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [LEVEL_W-1:0] out_level_r;

  // Control
  ucode_t  uc;
  status_t sts;
  logic    in_fire;
  logic    out_full;
  logic    commit;
  logic    div_start;
  logic    div_busy;
  logic [LEVEL_W-1:0] div_quo;
  logic [PER_W-1:0]   div_rem;

  // Combinational datapath
  logic [RATE_W-1:0]               rate_sel;
  logic [PER_W-1:0]                rem_sel;
  logic [LEVEL_W-1:0]              full_q;
  logic [ELAP_W+RATE_W+FRAC_W:0]   sum_w;
  logic signed [LEVEL_W+2:0]       next_w;
  logic signed [LEVEL_W+2:0]       top_w;
  logic                            floor_hit;
  logic                            ceil_hit;
  logic [LEVEL_W-1:0]              level_new;

  ali_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .uc    (uc)
  );

  ali_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (dvd_r),
    .divisor   (period_r),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Handshakes and status for the sequencer
  assign in_chan.ready  = (uc.op == OP_FETCH);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_full       = out_valid_r && !out_chan.ready;
  assign commit         = (uc.op == OP_COMMIT) && !out_full;
  assign div_start      = (uc.op == OP_CHECK) && !sat_r;
  assign cfg_chan.ready = 1'b1;

  assign rate_sel = (cls_r == CLS_HIGH) ? rise_rate_r : decay_rate_r;
  assign rem_sel  = (cls_r == CLS_HIGH) ? rise_rem_r : decay_rem_r;
  assign full_q   = {max_r, {FRAC_W{1'b0}}};

  assign sts.no_item  = !in_fire;
  assign sts.no_term  = (cls_r == CLS_BLINK) || (rate_sel == '0) ||
                        (period_r == '0) || (elapsed_r == '0);
  assign sts.sat      = sat_r;
  assign sts.div_busy = div_busy;
  assign sts.out_full = out_full;

  // Scaled elapsed time plus carried remainder
  assign sum_w = {1'b0, prod_r, {FRAC_W{1'b0}}} + (ELAP_W+RATE_W+FRAC_W+1)'(rem_new_r);

  // New level before clamping, and the clamp
  always_comb begin
    next_w = $signed({3'b000, level_r}) + (LEVEL_W+3)'(contrib_r);
    if (cls_r == CLS_HIGH) begin
      next_w = next_w + $signed({3'b000, term_r});
    end else begin
      next_w = next_w - $signed({3'b000, term_r});
    end
    top_w     = $signed({3'b000, full_q});
    floor_hit = (next_w <= 0);
    // Floor first: a level clamped to zero also meets a zero ceiling
    ceil_hit  = floor_hit ? (top_w == 0) : (next_w >= top_w);
    if (ceil_hit) begin
      level_new = full_q;
    end else if (floor_hit) begin
      level_new = '0;
    end else begin
      level_new = next_w[LEVEL_W-1:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_rate_r  <= '0;
      decay_rate_r <= '0;
      period_r     <= '0;
      max_r        <= '1;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.wr_index)
        CFG_RISE_RATE:  rise_rate_r  <= cfg_chan.wr_data[RATE_W-1:0];
        CFG_DECAY_RATE: decay_rate_r <= cfg_chan.wr_data[RATE_W-1:0];
        CFG_UPDATE_PER: period_r     <= cfg_chan.wr_data[PER_W-1:0];
        CFG_LEVEL_MAX:  max_r        <= cfg_chan.wr_data[MAX_W-1:0];
        default: ;
      endcase
    end
  end

  // Working registers, driven by the current step
  always_ff @(posedge clk) begin
    case (uc.op)
      OP_FETCH: begin
        if (in_fire) begin
          cls_r     <= in_chan.signal_class;
          contrib_r <= in_chan.contribution;
          elapsed_r <= in_chan.elapsed_ms;
        end
      end
      OP_PREP: begin
        prod_r    <= (ELAP_W+RATE_W)'(elapsed_r) * (ELAP_W+RATE_W)'(rate_sel);
        mp_r      <= 32'(full_q) * 32'(period_r);
        term_r    <= '0;
        rem_new_r <= rem_sel;
      end
      OP_SUM: begin
        sat_r <= (sum_w > (ELAP_W+RATE_W+FRAC_W+1)'(mp_r));
        dvd_r <= sum_w[31:0];
      end
      OP_CHECK: begin
        if (sat_r) begin
          term_r    <= full_q;
          rem_new_r <= '0;
        end
      end
      OP_DIV_WAIT: begin
        if (!div_busy) begin
          term_r    <= div_quo;
          rem_new_r <= div_rem;
        end
      end
      default: ;
    endcase
  end

  // Commit the level and remainders
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      rise_rem_r  <= '0;
      decay_rem_r <= '0;
    end else if (commit) begin
      level_r <= level_new;
      if (cls_r == CLS_HIGH) begin
        rise_rem_r <= ceil_hit ? '0 : rem_new_r;
        if (floor_hit) begin
          decay_rem_r <= '0;
        end
      end else if (cls_r == CLS_BLINK) begin
        if (ceil_hit) begin
          rise_rem_r <= '0;
        end
        if (floor_hit) begin
          decay_rem_r <= '0;
        end
      end else begin
        decay_rem_r <= floor_hit ? '0 : rem_new_r;
        if (ceil_hit) begin
          rise_rem_r <= '0;
        end
      end
    end
  end

  // Output register
  always_comb begin
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_level_r <= level_new;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.level = out_level_r;

`ifndef ASSERT_OFF
  a_commit_to_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (uc.op == OP_FETCH))
    else $error("sequencer did not return to fetch after commit");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> div_busy)
    else $error("divider did not start");

  a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
    ((uc.op == OP_DIV_WAIT) && !div_busy) |=> (rem_new_r < period_r))
    else $error("carried remainder not below the period");

  a_level_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.level <= full_q))
    else $error("level above ceiling");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the activity level integrator. A directed table
// covers reset values, field extremes, saturation at both ends, the spare
// class code and a remainder left above full range by reconfiguration; then
// random phases reload every register and stream items under random idling
// on both channels. Each result is checked against a bit-exact predictor or a fixed table level.
// ----------------------------------------------------------------------------
module tb_top;
  import ali_pkg::*;

  localparam logic [CLS_W-1:0]  CLS_SPARE   = 2'd3;
  localparam logic [CIDX_W-1:0] CFG_NO_REG  = 4'd15;
  localparam int                NUM_PHASES  = 31;
  localparam int                PHASE_ITEMS = 50;
  localparam int                HOLD_PHASE  = 4;
  localparam int                PAUSE_PHASE = 9;
  localparam int                HOLD_CYC    = 300;
  localparam int                DRAIN_CYC   = 48;
  localparam int                LIMIT_CYC   = 600000;
  localparam int                MAX_SHOWN   = 10;

  typedef struct {
    bit                        is_cfg;
    logic [CIDX_W-1:0]         reg_idx;
    logic [CDAT_W-1:0]         reg_val;
    logic [CLS_W-1:0]          cls;
    logic signed [CONTR_W-1:0] contrib;
    logic [ELAP_W-1:0]         elapsed;
    bit                        fixed;
    logic [LEVEL_W-1:0]        level;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ali_in_if  in_if ();
  ali_out_if out_if ();
  ali_cfg_if cfg_if ();

  activity_level_integrator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #6 clk = ~clk;

  // Predictor copy of registers and state
  logic [RATE_W-1:0]  cfg_rise;
  logic [RATE_W-1:0]  cfg_decay;
  logic [PER_W-1:0]   cfg_period;
  logic [MAX_W-1:0]   cfg_max;
  logic [LEVEL_W-1:0] lvl_now;
  logic [15:0]        rem_rise;
  logic [15:0]        rem_decay;

  logic [LEVEL_W-1:0] level_q [$];
  dir_row_t           dir_tab [$];
  int                 err_cnt = 0;
  bit                 tx_idle_on = 1'b0;
  bit                 rx_idle_on = 1'b0;
  bit                 hold_req = 1'b0;

  // Rate term with carried remainder; full-range steps saturate the term
  function automatic longint unsigned rate_step(input logic [RATE_W-1:0] rate,
                                                input logic [ELAP_W-1:0] elapsed,
                                                inout logic [15:0] rem);
    longint unsigned full, rate_q, span, thresh, num;
    if (rate == 0 || cfg_period == 0 || elapsed == 0) return '0;
    full   = 64'(cfg_max) << FRAC_W;
    rate_q = 64'(rate) << FRAC_W;
    span   = full * 64'(cfg_period);
    thresh = (64'(rem) > span) ? '0 : (span - 64'(rem)) / rate_q;
    if (64'(elapsed) > thresh) begin
      rem = '0;
      return full;
    end
    num = 64'(elapsed) * rate_q + 64'(rem);
    rem = 16'(num % 64'(cfg_period));
    return num / 64'(cfg_period);
  endfunction

  // Advance the predicted level by one item and return it
  function automatic logic [LEVEL_W-1:0] predict_level(input logic [CLS_W-1:0] cls,
                                                       input logic signed [CONTR_W-1:0] contrib,
                                                       input logic [ELAP_W-1:0] elapsed);
    longint nxt, top;
    nxt = longint'(lvl_now) + longint'(contrib);
    top = longint'(cfg_max) << FRAC_W;
    if (cls == CLS_HIGH) begin
      nxt = nxt + longint'(rate_step(cfg_rise, elapsed, rem_rise));
    end else if (cls != CLS_BLINK) begin
      nxt = nxt - longint'(rate_step(cfg_decay, elapsed, rem_decay));
    end
    // Floor is checked first, so a zero ceiling clears both remainders
    if (nxt <= 0) begin
      nxt = 0;
      rem_decay = '0;
    end
    if (nxt >= top) begin
      nxt = top;
      rem_rise = '0;
    end
    lvl_now = nxt[LEVEL_W-1:0];
    return lvl_now;
  endfunction

  function automatic dir_row_t item_row(input logic [CLS_W-1:0] cls,
                                        input logic signed [CONTR_W-1:0] contrib,
                                        input logic [ELAP_W-1:0] elapsed,
                                        input bit fixed = 1'b0,
                                        input logic [LEVEL_W-1:0] level = '0);
    dir_row_t r;
    r = '{is_cfg: 1'b0, reg_idx: '0, reg_val: '0, cls: cls, contrib: contrib,
          elapsed: elapsed, fixed: fixed, level: level};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CIDX_W-1:0] idx,
                                       input logic [CDAT_W-1:0] val);
    dir_row_t r;
    r = '{is_cfg: 1'b1, reg_idx: idx, reg_val: val, cls: '0, contrib: '0,
          elapsed: '0, fixed: 1'b0, level: '0};
    return r;
  endfunction

  // Offer one item, hold it until taken, then log its expected level
  task automatic send_item(input logic [CLS_W-1:0] cls,
                           input logic signed [CONTR_W-1:0] contrib,
                           input logic [ELAP_W-1:0] elapsed,
                           input bit fixed = 1'b0,
                           input logic [LEVEL_W-1:0] level = '0);
    logic [LEVEL_W-1:0] pred;
    in_if.valid        <= 1'b1;
    in_if.signal_class <= cls;
    in_if.contribution <= contrib;
    in_if.elapsed_ms   <= elapsed;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pred = predict_level(cls, contrib, elapsed);
    level_q.push_back(fixed ? level : pred);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Write one register; valid stays up for a following write
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] val);
    cfg_if.valid    <= 1'b1;
    cfg_if.wr_index <= idx;
    cfg_if.wr_data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_RISE_RATE:  cfg_rise   = val[RATE_W-1:0];
      CFG_DECAY_RATE: cfg_decay  = val[RATE_W-1:0];
      CFG_UPDATE_PER: cfg_period = val[PER_W-1:0];
      CFG_LEVEL_MAX:  cfg_max    = val[MAX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (level_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Reload every register for one random phase
  task automatic load_setting(input int phase);
    logic [RATE_W-1:0] rise, decay;
    logic [PER_W-1:0]  per;
    logic [MAX_W-1:0]  top;
    if (phase == 0) begin
      rise = 8'hFF; decay = 8'hFF; per = 16'hFFFF; top = 8'hFF;
    end else if (phase == 1) begin
      rise = 8'd1; decay = 8'd1; per = 16'd1; top = 8'd1;
    end else begin
      case ($urandom_range(0, 5))
        0:       rise = '0;
        1:       rise = 8'hFF;
        default: rise = 8'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 5))
        0:       decay = '0;
        1:       decay = 8'hFF;
        default: decay = 8'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 9))
        0:       per = '0;
        1:       per = 16'hFFFF;
        2:       per = 16'd1;
        3:       per = 16'($urandom);
        default: per = 16'($urandom_range(2, 3000));
      endcase
      case ($urandom_range(0, 6))
        0:       top = '0;
        1, 2:    top = 8'hFF;
        default: top = 8'($urandom_range(1, 254));
      endcase
    end
    write_reg(CFG_RISE_RATE, {8'd0, rise});
    write_reg(CFG_DECAY_RATE, {8'd0, decay});
    write_reg(CFG_UPDATE_PER, per);
    write_reg(CFG_LEVEL_MAX, {8'd0, top});
    if ($urandom_range(0, 7) == 0) write_reg(CFG_NO_REG, 16'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  // Random item: class mix, short and long elapsed times, contribution extremes
  task automatic send_random_item();
    logic [CLS_W-1:0]          cls;
    logic signed [CONTR_W-1:0] contrib;
    logic [ELAP_W-1:0]         elapsed;
    int unsigned               span;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6:      cls = CLS_LOW;
      7, 8, 9, 10, 11, 12, 13:  cls = CLS_HIGH;
      14, 15, 16:               cls = CLS_BLINK;
      default:                  cls = CLS_SPARE;
    endcase
    case ($urandom_range(0, 9))
      0:       contrib = 16'sh7FFF;
      1:       contrib = 16'sh8000;
      2, 3:    contrib = 16'($urandom);
      default: contrib = 16'($urandom_range(0, 1024) - 512);
    endcase
    span = 32'(cfg_period);
    span = span * 3 + 4;
    case ($urandom_range(0, 9))
      0:       elapsed = '0;
      1:       elapsed = 32'hFFFF_FFFF;
      2:       elapsed = $urandom;
      3:       elapsed = $urandom_range(1, 16);
      default: elapsed = $urandom_range(1, span);
    endcase
    send_item(cls, contrib, elapsed);
  endtask

  // Check each taken result against the oldest expected level
  always @(posedge clk) begin : result_check
    logic [LEVEL_W-1:0] want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (level_q.size() == 0) begin
        if (err_cnt < MAX_SHOWN) $display("unexpected result: level %0d", out_if.level);
        err_cnt++;
      end else begin
        want = level_q.pop_front();
        if (out_if.level !== want) begin
          if (err_cnt < MAX_SHOWN) begin
            $display("level mismatch: expected %0d, got %0d", want, out_if.level);
          end
          err_cnt++;
        end
      end
    end
  end

  // Result side: random stall bursts and one long hold-off on request
  initial begin : result_ready
    int stall;
    stall = 0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYC;
      end else if (stall == 0 && rx_idle_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 7);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Stop a hung run
  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < LIMIT_CYC) begin
      @(posedge clk);
      cyc++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    bit in_cfg;
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.signal_class <= '0;
    in_if.contribution <= '0;
    in_if.elapsed_ms   <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.wr_index    <= '0;
    cfg_if.wr_data     <= '0;
    cfg_rise   = '0;
    cfg_decay  = '0;
    cfg_period = '0;
    cfg_max    = 8'hFF;
    lvl_now    = '0;
    rem_rise   = '0;
    rem_decay  = '0;
    in_cfg     = 1'b0;

    // Reset values: no rate terms, full ceiling
    dir_tab.push_back(item_row(CLS_LOW, 16'sh0000, 32'hFFFF_FFFF, 1'b1, 16'd0));
    dir_tab.push_back(item_row(CLS_HIGH, 16'sh7FFF, 32'hFFFF_FFFF, 1'b1, 16'd32767));
    dir_tab.push_back(item_row(CLS_BLINK, 16'sh7FFF, 32'd0, 1'b1, 16'd65280));
    dir_tab.push_back(item_row(CLS_SPARE, 16'sh8000, 32'd1, 1'b1, 16'd32512));
    dir_tab.push_back(item_row(CLS_BLINK, 16'sh8000, 32'd0, 1'b1, 16'd0));
    // Fastest rates over the longest period
    dir_tab.push_back(cfg_row(CFG_RISE_RATE, 16'd255));
    dir_tab.push_back(cfg_row(CFG_DECAY_RATE, 16'd255));
    dir_tab.push_back(cfg_row(CFG_UPDATE_PER, 16'hFFFF));
    dir_tab.push_back(cfg_row(CFG_LEVEL_MAX, 16'd255));
    dir_tab.push_back(item_row(CLS_HIGH, 16'sh0000, 32'd1));
    dir_tab.push_back(item_row(CLS_HIGH, 16'sh0000, 32'd1));
    dir_tab.push_back(item_row(CLS_HIGH, 16'sh0000, 32'd0));
    dir_tab.push_back(item_row(CLS_HIGH, 16'sh0000, 32'hFFFF_FFFF, 1'b1, 16'd65280));
    dir_tab.push_back(item_row(CLS_LOW, 16'sh0000, 32'd1000));
    dir_tab.push_back(item_row(CLS_SPARE, 16'sh0000, 32'd1000));
    dir_tab.push_back(item_row(CLS_BLINK, 16'sh0100, 32'hFFFF_FFFF));
    dir_tab.push_back(item_row(CLS_LOW, 16'sh0000, 32'hFFFF_FFFF, 1'b1, 16'd0));
    dir_tab.push_back(item_row(CLS_HIGH, 16'sh0000, 32'd1));
    // Shrink the range under a large rise remainder
    dir_tab.push_back(cfg_row(CFG_UPDATE_PER, 16'd1));
    dir_tab.push_back(cfg_row(CFG_LEVEL_MAX, 16'd1));
    dir_tab.push_back(item_row(CLS_HIGH, 16'sh0000, 32'd1, 1'b1, 16'd256));
    // Zero ceiling pins the level
    dir_tab.push_back(cfg_row(CFG_LEVEL_MAX, 16'd0));
    dir_tab.push_back(cfg_row(CFG_RISE_RATE, 16'd1));
    dir_tab.push_back(cfg_row(CFG_DECAY_RATE, 16'd1));
    dir_tab.push_back(item_row(CLS_BLINK, 16'sh7FFF, 32'd5, 1'b1, 16'd0));
    dir_tab.push_back(item_row(CLS_HIGH, 16'sh0000, 32'd1, 1'b1, 16'd0));
    // Zero period drops the rate term
    dir_tab.push_back(cfg_row(CFG_LEVEL_MAX, 16'd255));
    dir_tab.push_back(cfg_row(CFG_UPDATE_PER, 16'd0));
    dir_tab.push_back(item_row(CLS_HIGH, 16'sh1234, 32'hFFFF_FFFF));
    dir_tab.push_back(item_row(CLS_LOW, 16'sh0000, 32'hFFFF_FFFF));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        if (!in_cfg) begin
          in_if.valid <= 1'b0;
          wait_idle();
          in_cfg = 1'b1;
        end
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        if (in_cfg) begin
          cfg_if.valid <= 1'b0;
          in_cfg = 1'b0;
        end
        send_item(dir_tab[i].cls, dir_tab[i].contrib, dir_tab[i].elapsed,
                  dir_tab[i].fixed, dir_tab[i].level);
      end
    end

    // Random phases, each under a fresh setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_if.valid <= 1'b0;
      wait_idle();
      load_setting(ph);
      if (ph >= NUM_PHASES - 3) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      if (ph == HOLD_PHASE) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Hold the sender until every pending level has come back
        if (ph == PAUSE_PHASE && k == PHASE_ITEMS / 2) begin
          in_if.valid <= 1'b0;
          @(posedge clk);
          while (level_q.size() != 0) @(posedge clk);
        end
        send_random_item();
      end
    end

    in_if.valid <= 1'b0;
    wait_idle();
    if (err_cnt == 0 && level_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ali_pkg.sv
rtl/ali_ifs.sv
rtl/ali_seq.sv
rtl/ali_div.sv
rtl/activity_level_integrator.sv
tb/sv/tb_top.sv
